FILE: sv/hl2d_pkg.sv
// ----------------------------------------------------------------------------
// hl2d_pkg
// Shared constants, types and arithmetic helpers of the 2D Haar lifting block.
// ----------------------------------------------------------------------------
package hl2d_pkg;

  localparam int TILE_SIDE = 16;
  localparam int FRAC_BITS = 8;
  localparam int CELLS     = TILE_SIDE * TILE_SIDE;
  localparam int AW        = $clog2(CELLS);
  localparam int LW        = $clog2(TILE_SIDE) + 1;
  localparam int VW        = 24;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam logic DIR_FWD  = 1'b0;
  localparam logic DIR_INV  = 1'b1;

  typedef logic signed [VW-1:0] val_t;
  typedef logic [AW-1:0]        addr_t;

  // controller to datapath
  typedef struct packed {
    logic       load_we;
    addr_t      load_addr;
    logic       rd_en;
    logic       rd_bank;
    addr_t      rd_addr;
    logic [1:0] quad_slot;
    logic       wr_en;
    logic       wr_bank;
    addr_t      wr_addr;
    logic [1:0] wr_slot;
    logic       inv;
    logic       carry;
  } ctl_t;

  function automatic val_t sat24(input logic signed [VW+2:0] x);
    logic signed [VW+2:0] hi;
    logic signed [VW+2:0] lo;
    hi = (VW+3)'(signed'(24'sh7FFFFF));
    lo = (VW+3)'(signed'(-24'sh800000));
    if (x > hi) return 24'sh7FFFFF;
    if (x < lo) return -24'sh800000;
    return x[VW-1:0];
  endfunction

endpackage

FILE: sv/haar_lift_2d_multilevel.sv
// ----------------------------------------------------------------------------
// haar_lift_2d_multilevel
// Loads a square tile, runs a full-depth 2D Haar lifting transform or its
// inverse, and streams the tile out on read transactions.
// A read value passes the buffer read register and the output register; a new
// transaction is accepted only after the previous value is captured, which
// waits while the output is stalled. Each level reads one buffer port and
// writes the other, then carries the entries outside its area unchanged.
// Reset: control state clears; buffer contents stay undefined until written.
// ----------------------------------------------------------------------------
module haar_lift_2d_multilevel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [23:0] sample
  input  logic        s_axis_tuser,  // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [23:0] value
  output logic        m_axis_tlast
);
  import hl2d_pkg::*;

  logic   dir_q;
  logic   cap;
  ctl_t   ctl;
  val_t   rdv;
  val_t   out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dir_q <= DIR_FWD;
    else if (cfg_we_i) dir_q <= cfg_wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (cap) out_q <= rdv;
  end

  hl2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .dir_i       (dir_q),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_cap_o   (cap),
    .ctl_o       (ctl)
  );

  hl2d_datapath u_dp (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .load_val_i (s_axis_tdata),
    .rd_val_o   (rdv)
  );

  assign m_axis_tdata = out_q;
endmodule

FILE: sv/hl2d_datapath.sv
// ----------------------------------------------------------------------------
// hl2d_datapath
// Ping-pong buffers, four-entry operand group and lifting arithmetic.
// ----------------------------------------------------------------------------
module hl2d_datapath (
  input  logic               clk_i,
  input  hl2d_pkg::ctl_t     ctl_i,
  input  hl2d_pkg::val_t     load_val_i,
  output hl2d_pkg::val_t     rd_val_o
);
  import hl2d_pkg::*;

  val_t mem0 [CELLS];
  val_t mem1 [CELLS];
  val_t rd0_q, rd1_q;
  logic rd_bank_q, rd_vld_q;
  logic [1:0] slot_q;
  val_t quad_q [4];
  val_t opnd [4];
  val_t rdv;
  val_t res;
  logic signed [VW+2:0] a, b, c, d, ab, cd, lo, h1, h2, h3;

  assign rdv      = rd_bank_q ? rd1_q : rd0_q;
  assign rd_val_o = rdv;

  always_ff @(posedge clk_i) begin
    rd0_q <= mem0[ctl_i.rd_addr];
    rd1_q <= mem1[ctl_i.rd_addr];
    if (ctl_i.load_we) mem0[ctl_i.load_addr] <= load_val_i;
    else if (ctl_i.wr_en && !ctl_i.wr_bank) mem0[ctl_i.wr_addr] <= res;
    if (ctl_i.wr_en && ctl_i.wr_bank) mem1[ctl_i.wr_addr] <= res;
  end

  always_ff @(posedge clk_i) begin
    rd_bank_q <= ctl_i.rd_bank;
    rd_vld_q  <= ctl_i.rd_en;
    slot_q    <= ctl_i.quad_slot;
    if (rd_vld_q) quad_q[slot_q] <= rdv;
  end

  // forward the value still on the read port into its slot
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      opnd[k] = (rd_vld_q && slot_q == 2'(k)) ? rdv : quad_q[k];
    end
  end

  always_comb begin
    a  = (VW+3)'(opnd[0]);
    b  = (VW+3)'(opnd[1]);
    c  = (VW+3)'(opnd[2]);
    d  = (VW+3)'(opnd[3]);
    ab = (a + b) >>> 1;
    cd = (c + d) >>> 1;
    lo = (a + b + c + d) >>> 2;
    h1 = b;
    h2 = c;
    h3 = d;
    res = opnd[ctl_i.wr_slot];
    if (!ctl_i.carry) begin
      if (!ctl_i.inv) begin
        case (ctl_i.wr_slot)
          2'd0:    res = sat24(lo);
          2'd1:    res = sat24(lo - ab);
          2'd2:    res = sat24(a - ab);
          default: res = sat24(c - cd);
        endcase
      end else begin
        case (ctl_i.wr_slot)
          2'd0:    res = sat24(a - h1 + h2);
          2'd1:    res = sat24(a - h1 - h2);
          2'd2:    res = sat24(a + h1 + h3);
          default: res = sat24(a + h1 - h3);
        endcase
      end
    end
  end
endmodule

FILE: sv/hl2d_ctrl.sv
// ----------------------------------------------------------------------------
// hl2d_ctrl
// Sequencer for loading, level-by-level lifting and ordered read-out.
// ----------------------------------------------------------------------------
module hl2d_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_cmd_i,
  input  logic           dir_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output logic           out_last_o,
  input  logic           out_ready_i,
  output logic           out_cap_o,
  output hl2d_pkg::ctl_t ctl_o
);
  import hl2d_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_WR, S_CARRY, S_NEXT, S_OUT, S_OWAIT
  } state_e;

  state_e state_q;
  logic [AW:0] load_cnt_q;
  addr_t       read_cnt_q;
  logic        ready_q, res_bank_q, inv_q, src_q;
  logic [LW-1:0] lvl_q;
  addr_t       grp_q;
  logic [2:0]  sub_q;
  logic [AW:0] cidx_q;
  logic        ovld_q, olast_q;

  logic [LW-1:0] side, half;
  addr_t row, col, gsz;
  addr_t qaddr [4];
  addr_t gaddr [4];
  logic [AW:0] area;
  logic acc;

  always_comb begin
    side = LW'(1) << lvl_q;
    half = side >> 1;
    gsz  = AW'(half) * AW'(half);
    area = (AW+1)'(side) * (AW+1)'(side);
    row  = AW'(grp_q >> (lvl_q - 1'b1)) << 1;
    col  = AW'(grp_q & (AW'(half) - 1'b1)) << 1;
    qaddr[0] = AW'(row * AW'(side) + col);
    qaddr[1] = qaddr[0] + 1'b1;
    qaddr[2] = qaddr[0] + AW'(side);
    qaddr[3] = qaddr[2] + 1'b1;
    gaddr[0] = grp_q;
    gaddr[1] = grp_q + gsz;
    gaddr[2] = grp_q + AW'(2 * gsz);
    gaddr[3] = grp_q + AW'(3 * gsz);
  end

  assign acc         = in_valid_i && in_ready_o;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = ovld_q;
  assign out_last_o  = olast_q;
  assign out_cap_o   = (state_q == S_OWAIT) && (!ovld_q || out_ready_i);

  always_comb begin
    ctl_o = '0;
    ctl_o.inv = inv_q;
    ctl_o.load_we = acc && in_cmd_i == CMD_LOAD;
    ctl_o.load_addr = load_cnt_q[AW-1:0];
    ctl_o.rd_bank = src_q;
    ctl_o.wr_bank = !src_q;
    ctl_o.quad_slot = sub_q[1:0];
    ctl_o.wr_slot = sub_q[1:0];
    case (state_q)
      S_RD: begin
        ctl_o.rd_en = 1'b1;
        ctl_o.rd_addr = inv_q ? gaddr[sub_q[1:0]] : qaddr[sub_q[1:0]];
      end
      S_WR: begin
        ctl_o.wr_en = 1'b1;
        ctl_o.wr_addr = inv_q ? qaddr[sub_q[1:0]] : gaddr[sub_q[1:0]];
      end
      S_CARRY: begin
        ctl_o.rd_en = sub_q[0] == 1'b0;
        ctl_o.rd_addr = cidx_q[AW-1:0];
        ctl_o.quad_slot = 2'd0;
        ctl_o.wr_en = sub_q[0] == 1'b1;
        ctl_o.wr_addr = cidx_q[AW-1:0];
        ctl_o.wr_slot = 2'd0;
        ctl_o.carry = 1'b1;
      end
      default: begin
        ctl_o.rd_bank = res_bank_q;
        ctl_o.rd_addr = read_cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; load_cnt_q <= '0; read_cnt_q <= '0; ready_q <= 1'b0;
      res_bank_q <= 1'b0; inv_q <= 1'b0; src_q <= 1'b0; lvl_q <= '0;
      grp_q <= '0; sub_q <= '0; cidx_q <= '0; ovld_q <= 1'b0; olast_q <= 1'b0;
    end else begin
      if (out_cap_o) ovld_q <= 1'b1;
      else if (out_ready_i) ovld_q <= 1'b0;
      case (state_q)
        S_IDLE: if (acc) begin
          if (in_cmd_i == CMD_LOAD) begin
            ready_q <= 1'b0;
            read_cnt_q <= '0;
            if (load_cnt_q == (AW+1)'(CELLS - 1)) begin
              load_cnt_q <= '0;
              inv_q <= dir_i;
              src_q <= 1'b0;
              lvl_q <= (dir_i == DIR_INV) ? LW'(1) : LW'(LW - 1);
              grp_q <= '0; sub_q <= '0;
              state_q <= S_RD;
            end else load_cnt_q <= load_cnt_q + 1'b1;
          end else if (ready_q) state_q <= S_OUT;
        end
        S_RD: begin
          if (sub_q == 3'd3) begin
            sub_q <= '0; state_q <= S_WR;
          end else sub_q <= sub_q + 1'b1;
        end
        S_WR: begin
          if (sub_q == 3'd3) begin
            sub_q <= '0;
            if (grp_q == gsz - 1'b1) begin
              grp_q <= '0; cidx_q <= area; state_q <= S_CARRY;
            end else begin
              grp_q <= grp_q + 1'b1; state_q <= S_RD;
            end
          end else sub_q <= sub_q + 1'b1;
        end
        S_CARRY: begin
          if (cidx_q >= (AW+1)'(CELLS)) state_q <= S_NEXT;
          else if (sub_q[0]) begin
            sub_q <= '0;
            cidx_q <= cidx_q + 1'b1;
          end else sub_q <= 3'd1;
        end
        S_NEXT: begin
          src_q <= !src_q;
          sub_q <= '0;
          if (inv_q ? (lvl_q == LW'(LW - 1)) : (lvl_q == LW'(1))) begin
            res_bank_q <= !src_q; ready_q <= 1'b1; state_q <= S_IDLE;
          end else begin
            lvl_q <= inv_q ? lvl_q + 1'b1 : lvl_q - 1'b1;
            state_q <= S_RD;
          end
        end
        S_OUT: state_q <= S_OWAIT;
        S_OWAIT: if (out_cap_o) begin
          olast_q <= read_cnt_q == AW'(CELLS - 1);
          read_cnt_q <= read_cnt_q + 1'b1;
          if (read_cnt_q == AW'(CELLS - 1)) ready_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready while busy");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_cap_o && read_cnt_q == AW'(CELLS - 1)) |=> !ready_q)
    else $error("results still pending after last");
  a_no_wr_bank_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.wr_en |-> ctl_o.wr_bank != ctl_o.rd_bank) else $error("bank clash");
endmodule
